@@ design/aes_pkg.sv @@
// AES-128 package: S-box, GF(2^8) helpers, round transforms and shared constants.
// No dependencies; used by the channel interface, the cipher module and its testbench.
package aes_pkg;

  localparam int unsigned HalfW = 64;
  localparam int unsigned BlockW = 128;
  localparam int unsigned Rounds = 10;
  localparam int unsigned CfgIdxW = 1;

  typedef logic [HalfW-1:0] half_t;
  typedef logic [BlockW-1:0] block_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_t;

  localparam logic [7:0] GfPoly = 8'h1b;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constants for rounds 1..10, top byte of the word
  localparam logic [7:0] Rcon [Rounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
  endfunction

  // Byte n of a block in FIPS order; byte 0 is bits 127:120
  function automatic logic [7:0] get_byte(input block_t s, input int unsigned n);
    get_byte = s[BlockW-1-8*n -: 8];
  endfunction

  // SubBytes followed by ShiftRows
  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(r+4*c) -: 8] = Sbox[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      t[BlockW-1-32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                               xtime(a1) ^ xtime(a2) ^ a2 ^ a3 ^ a0,
                               xtime(a2) ^ xtime(a3) ^ a3 ^ a0 ^ a1,
                               xtime(a3) ^ xtime(a0) ^ a0 ^ a1 ^ a2};
    end
    mix_columns = t;
  endfunction

  // One step of the AES-128 key schedule
  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {Sbox[w3[23:16]] ^ rc, Sbox[w3[15:8]], Sbox[w3[7:0]], Sbox[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage

@@ design/aes_if.sv @@
// Valid/ready channel interface carrying one 128-bit block as two 64-bit halves.
// Depends on aes_pkg for the half width.
interface aes_if;
  import aes_pkg::*;

  logic  valid;
  logic  ready;
  half_t data_high;
  half_t data_low;

  modport source (output valid, output data_high, output data_low, input ready);
  modport sink (input valid, input data_high, input data_low, output ready);
endinterface

@@ design/aes128_block_encrypt.sv @@
// AES-128 block encryption top level: key registers and an unrolled round pipeline.
// Depends on aes_pkg and aes_if.
//
// Encrypts one 128-bit block per cycle while the output is not stalled. Each word
// passes eleven register stages (the initial key add plus one stage per round, which
// holds one round and the matching key schedule step). The round key travels with
// the data, so a key write takes effect on the next word accepted. A stall freezes
// the whole pipeline; ready is high whenever the last stage is empty or being
// drained.
module aes128_block_encrypt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [aes_pkg::CfgIdxW-1:0]  cfg_index,
  input  aes_pkg::half_t               cfg_data,
  aes_if.sink                          plain,
  aes_if.source                        cipher
);
  import aes_pkg::*;

  localparam int unsigned Stages = Rounds + 1;

  half_t  key_high;
  half_t  key_low;
  logic   vld [Stages];
  block_t st  [Stages];
  block_t rk  [Stages];
  logic   advance;

  // Write the key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless a finished word is held at the output
  assign advance     = !vld[Stages-1] || cipher.ready;
  assign plain.ready = advance;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Stages; i++) vld[i] <= 1'b0;
    end else if (advance) begin
      vld[0] <= plain.valid;
      for (int i = 1; i < Stages; i++) vld[i] <= vld[i-1];
    end
  end

  // Stage 0: initial key add; later stages: one round each
  always_ff @(posedge clk) begin
    if (advance) begin
      st[0] <= {plain.data_high, plain.data_low} ^ {key_high, key_low};
      rk[0] <= {key_high, key_low};
      for (int i = 1; i < Stages; i++) begin
        rk[i] <= next_key(rk[i-1], Rcon[i-1]);
        if (i == Stages - 1) begin
          st[i] <= sub_shift(st[i-1]) ^ next_key(rk[i-1], Rcon[i-1]);
        end else begin
          st[i] <= mix_columns(sub_shift(st[i-1])) ^ next_key(rk[i-1], Rcon[i-1]);
        end
      end
    end
  end

  // Drive the result
  assign cipher.valid     = vld[Stages-1];
  assign cipher.data_high = st[Stages-1][BlockW-1:HalfW];
  assign cipher.data_low  = st[Stages-1][HalfW-1:0];

endmodule

@@ bench/aes128_block_encrypt_test.sv @@
// Testbench for aes128_block_encrypt: encrypts directed and random blocks under several keys
// and checks each ciphertext word against a local AES-128 predictor. Depends on aes_pkg, aes_if.
module aes128_block_encrypt_test;
  import aes_pkg::*;

  localparam int GapMax = 17;
  localparam int WatchLimit = 4000;
  localparam int DrainCycles = 30;
  localparam int RandomItems = 1650;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = REG_KEY_HIGH;
  half_t cfg_data = '0;

  aes_if plain_ch ();
  aes_if cipher_ch ();

  aes128_block_encrypt i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .plain(plain_ch.sink), .cipher(cipher_ch.source)
  );

  always #6 clk = ~clk;

  logic [7:0] sub_tab [256];
  block_t key_now = '0;
  block_t plain_pending [$];
  block_t cipher_expected [$];
  int errors = 0;
  int words_out = 0;

  // GF(2^8) arithmetic for building the substitution table and the column mix
  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    gf_dbl = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc, x;
    acc = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x;
      x = gf_dbl(x);
    end
    gf_mul = acc;
  endfunction

  // Build the S-box from the field inverse and the affine map
  initial begin
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = '0;
      for (int y = 1; y < 256; y++) begin
        if (x != 0 && gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      end
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_tab[x] = b;
    end
  end

  function automatic block_t encrypt_block(input block_t pt, input block_t key);
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0] rc;
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] a0, a1, a2, a3;
    block_t res;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {sub_tab[t[23:16]], sub_tab[t[15:8]], sub_tab[t[7:0]], sub_tab[t[31:24]]}
            ^ {rc, 24'h0};
        rc = gf_dbl(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int n = 0; n < 16; n++) st[n] = pt[127-8*n -: 8];
    for (int rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        // substitute and shift rows
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) tmp[r+4*c] = sub_tab[st[r+4*((c+r)%4)]];
        st = tmp;
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            st[4*c]   = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
            st[4*c+1] = gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3 ^ a0;
            st[4*c+2] = gf_dbl(a2) ^ gf_dbl(a3) ^ a3 ^ a0 ^ a1;
            st[4*c+3] = gf_dbl(a3) ^ gf_dbl(a0) ^ a0 ^ a1 ^ a2;
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) st[r+4*c] = st[r+4*c] ^ w[4*rnd+c][31-8*r -: 8];
    end
    for (int n = 0; n < 16; n++) res[127-8*n -: 8] = st[n];
    encrypt_block = res;
  endfunction

  task automatic report(input string what, input half_t got, input half_t want);
    $display("mismatch %s: got %016h want %016h", what, got, want);
    errors++;
  endtask

  // Driver: offer plaintext words with random gaps, record expectations on acceptance
  int send_gap = 0;
  bit send_burst = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      plain_ch.valid <= 1'b0;
      plain_ch.data_high <= '0;
      plain_ch.data_low <= '0;
    end else begin
      if (plain_ch.valid && plain_ch.ready)
        cipher_expected.push_back(encrypt_block({plain_ch.data_high, plain_ch.data_low},
                                                key_now));
      if (!plain_ch.valid || plain_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          plain_ch.valid <= 1'b0;
        end else if (plain_pending.size() > 0) begin
          block_t b;
          b = plain_pending.pop_front();
          plain_ch.valid <= 1'b1;
          {plain_ch.data_high, plain_ch.data_low} <= b;
          if ($urandom_range(0, 63) == 0) send_burst <= ~send_burst;
          send_gap <= send_burst ? 0 : $urandom_range(0, GapMax);
        end else begin
          plain_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, once for a long stretch, and check each ciphertext word
  int recv_gap = 0;
  int long_hold = 0;
  bit recv_burst = 1'b0;
  bit held_once = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      cipher_ch.ready <= 1'b0;
    end else begin
      if (cipher_ch.valid && cipher_ch.ready) begin
        block_t want;
        words_out <= words_out + 1;
        if (cipher_expected.size() == 0) begin
          report("unexpected cipher_high", cipher_ch.data_high, '0);
        end else begin
          want = cipher_expected.pop_front();
          if (cipher_ch.data_high !== want[127:64])
            report("cipher_high", cipher_ch.data_high, want[127:64]);
          if (cipher_ch.data_low !== want[63:0])
            report("cipher_low", cipher_ch.data_low, want[63:0]);
        end
        if ($urandom_range(0, 63) == 0) recv_burst <= ~recv_burst;
        if (!held_once && words_out == 300) begin
          held_once <= 1'b1;
          long_hold <= 400;
          cipher_ch.ready <= 1'b0;
        end else begin
          recv_gap <= recv_burst ? 0 : $urandom_range(0, GapMax);
          cipher_ch.ready <= recv_burst;
        end
      end else if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        cipher_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        cipher_ch.ready <= (recv_gap == 1);
      end else begin
        cipher_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: stop when nothing moves while work is outstanding
  int quiet = 0;
  always @(posedge clk) begin
    if ((plain_ch.valid && plain_ch.ready) || (cipher_ch.valid && cipher_ch.ready) ||
        (plain_pending.size() == 0 && cipher_expected.size() == 0 && !plain_ch.valid))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_key(input block_t key);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_KEY_HIGH;
    cfg_data <= key[127:64];
    @(posedge clk);
    cfg_index <= REG_KEY_LOW;
    cfg_data <= key[63:0];
    key_now <= {key[127:64], key_now[63:0]};
    @(posedge clk);
    cfg_we <= 1'b0;
    key_now <= key;
  endtask

  task automatic wait_idle();
    while (plain_pending.size() > 0 || plain_ch.valid || cipher_expected.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic block_t rand_block();
    block_t b;
    for (int i = 0; i < 4; i++) b[32*i +: 32] = $urandom();
    case ($urandom_range(0, 15))
      0: b = '0;
      1: b = '1;
      2: b[127:64] = '0;
      3: b[63:0] = '1;
      default: ;
    endcase
    rand_block = b;
  endfunction

  // Stimulus: directed blocks, then random blocks under a series of keys
  initial begin
    block_t keys [6];
    keys[0] = 128'h000102030405060708090a0b0c0d0e0f;
    keys[1] = '1;
    keys[2] = 128'h2b7e151628aed2a6abf7158809cf4f3c;
    keys[3] = '0;
    keys[4] = {$urandom(), $urandom(), $urandom(), $urandom()};
    keys[5] = {$urandom(), $urandom(), $urandom(), $urandom()};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset key of zero
    plain_pending.push_back('0);
    plain_pending.push_back('1);
    for (int i = 0; i < 6; i++) plain_pending.push_back(rand_block());
    wait_idle();

    // standard vector and edge patterns
    write_key(keys[0]);
    plain_pending.push_back(128'h00112233445566778899aabbccddeeff);
    plain_pending.push_back('0);
    plain_pending.push_back('1);
    plain_pending.push_back({16{8'h55}});
    plain_pending.push_back({16{8'haa}});
    plain_pending.push_back(128'h1);
    plain_pending.push_back({1'b1, 127'h0});
    plain_pending.push_back({16{8'h9e}});
    wait_idle();

    write_key(keys[1]);
    plain_pending.push_back('0);
    plain_pending.push_back('1);
    plain_pending.push_back({64'h0, 64'hffffffffffffffff});
    plain_pending.push_back({64'hffffffffffffffff, 64'h0});
    wait_idle();

    // random phases, one key each
    for (int p = 0; p < 6; p++) begin
      write_key(p == 0 ? keys[2] : (p == 5 ? keys[3] : (p % 2 ? keys[4] : keys[5])));
      if (p == 3) write_key({$urandom(), $urandom(), $urandom(), $urandom()});
      for (int i = 0; i < RandomItems / 6; i++) plain_pending.push_back(rand_block());
      wait_idle();
    end

    if (errors == 0 && cipher_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/aes_pkg.sv
design/aes_if.sv
design/aes128_block_encrypt.sv
bench/aes128_block_encrypt_test.sv
